FILE: sv/cpspid_pkg.sv
// ----------------------------------------------------------------------------
// Cascade PID package
// Word types, register indexes and datapath widths shared by the cascade
// position/speed controller and its multiply-accumulate unit.
// ----------------------------------------------------------------------------
package cpspid_pkg;

  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 23;
  localparam int OLIM_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int ERR_W  = 17;
  localparam int DERR_W = 18;
  localparam int D2_W   = 19;
  localparam int INTG_W = 24;

  // Multiplier operand and product widths; the gain enters as a signed
  // value with a zero sign bit.
  localparam int OPND_W = 25;
  localparam int PROD_W = GAIN_W + 1 + OPND_W;
  localparam int MACC_W = PROD_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_OUTER_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_P = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_I = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_D = 3'd7;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
  } in_word_t;

  typedef struct packed {
    logic signed [9:0]  drive;
    logic signed [15:0] outer_command;
  } out_word_t;

  typedef struct packed {
    logic mul;
    logic clr;
    logic add;
  } mac_ctrl_t;

endpackage

FILE: sv/cpspid_mac.sv
// ----------------------------------------------------------------------------
// Cascade PID multiply-accumulate unit
// One registered gain-by-operand multiplier followed by an accumulator that
// sums the registered products of one loop.
// ----------------------------------------------------------------------------
module cpspid_mac (
  input  logic                                   clk,
  input  cpspid_pkg::mac_ctrl_t                  ctrl,
  input  logic        [cpspid_pkg::GAIN_W-1:0]   gain,
  input  logic signed [cpspid_pkg::OPND_W-1:0]   opnd,
  output logic signed [cpspid_pkg::MACC_W-1:0]   acc
);

  localparam int PW = cpspid_pkg::PROD_W;
  localparam int AW = cpspid_pkg::MACC_W;

  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] prod_ext;

  assign prod_ext = $signed({{(AW-PW){prod_r[PW-1]}}, prod_r});

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= $signed({1'b0, gain}) * opnd;
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.add) begin
      acc_r <= acc_r + prod_ext;
    end
  end

  assign acc = acc_r;

endmodule

FILE: sv/cascade_position_speed_pid.sv
// ----------------------------------------------------------------------------
// Cascade position/speed PID controller
// Positional outer PID feeding an incremental inner PID, computed by a small
// sequencer around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | setpoint, measured
//  out_    | output    | out_valid/out_stall| drive, outer_command
//  cfg_    | input     | cfg_valid/cfg_ready| register index, data
//
// A word is accepted only while the sequencer is idle, and the next word is
// taken once the result is registered and the sequencer is back in idle;
// six products go one at a time through the single multiplier.
// Reset clears the gains, limits and all loop history to zero.
// A stalled result holds the sequencer in its last step; no loop history
// is updated and no new word is taken until the result register is free.
// ----------------------------------------------------------------------------
module cascade_position_speed_pid #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  cpspid_pkg::in_word_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output cpspid_pkg::out_word_t                  out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cpspid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpspid_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int GW  = cpspid_pkg::GAIN_W;
  localparam int EW  = cpspid_pkg::ERR_W;
  localparam int DW  = cpspid_pkg::DERR_W;
  localparam int D2W = cpspid_pkg::D2_W;
  localparam int IW  = cpspid_pkg::INTG_W;
  localparam int OW  = cpspid_pkg::OPND_W;
  localparam int MW  = cpspid_pkg::MACC_W;
  localparam int ACC_W = GAIN_FRAC_BITS + 10;
  localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(500 * (1 << GAIN_FRAC_BITS));

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_PREP = 13'b0000000000010,
    S_OM0  = 13'b0000000000100,
    S_OM1  = 13'b0000000001000,
    S_OM2  = 13'b0000000010000,
    S_OADD = 13'b0000000100000,
    S_CMD  = 13'b0000001000000,
    S_IERR = 13'b0000010000000,
    S_IM0  = 13'b0000100000000,
    S_IM1  = 13'b0001000000000,
    S_IM2  = 13'b0010000000000,
    S_IADD = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [GW-1:0] op_gain_r, oi_gain_r, od_gain_r;
  logic [GW-1:0] ip_gain_r, ii_gain_r, id_gain_r;
  logic [cpspid_pkg::ILIM_W-1:0] ilim_r;
  logic [cpspid_pkg::OLIM_W-1:0] olim_r;

  cpspid_pkg::in_word_t  in_r;
  cpspid_pkg::out_word_t out_r;
  logic                  out_valid_r;

  logic signed [EW-1:0]    e_r, outer_err_r, ei_r, e1_r, e2_r;
  logic signed [DW-1:0]    de_r, dp_r;
  logic signed [D2W-1:0]   dd_r;
  logic signed [IW-1:0]    integ_r;
  logic signed [15:0]      cmd_r;
  logic signed [ACC_W-1:0] iacc_r;

  logic signed [EW-1:0]    e_nxt, ei_nxt;
  logic signed [DW-1:0]    de_nxt, dp_nxt;
  logic signed [D2W-1:0]   dd_nxt;
  logic signed [IW:0]      isum, ilim_s, iclamp;
  logic signed [MW-1:0]    macc, shifted, olim_s, cclamp;
  logic signed [MW:0]      asum, alim_s, aclamp;
  logic signed [ACC_W-1:0] iacc_nxt;
  logic signed [ACC_W-1:0] drive_full;

  cpspid_pkg::mac_ctrl_t   mac_ctrl;
  logic [GW-1:0]           mac_gain;
  logic signed [OW-1:0]    mac_opnd;

  logic in_acc, out_free;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  cpspid_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .gain (mac_gain),
    .opnd (mac_opnd),
    .acc  (macc)
  );

  // Outer error, its difference and the clamped error sum.
  always_comb begin
    e_nxt  = EW'(in_r.setpoint) - EW'(in_r.measured);
    de_nxt = DW'(e_nxt) - DW'(outer_err_r);
    isum   = (IW+1)'(integ_r) + (IW+1)'(e_nxt);
    ilim_s = $signed({2'b00, ilim_r});
    if (isum > ilim_s) begin
      iclamp = ilim_s;
    end else if (isum < -ilim_s) begin
      iclamp = -ilim_s;
    end else begin
      iclamp = isum;
    end
  end

  // Outer command: floor scaling of the product sum, then the clamp.
  always_comb begin
    shifted = macc >>> GAIN_FRAC_BITS;
    olim_s  = $signed({{(MW-cpspid_pkg::OLIM_W){1'b0}}, olim_r});
    if (shifted > olim_s) begin
      cclamp = olim_s;
    end else if (shifted < -olim_s) begin
      cclamp = -olim_s;
    end else begin
      cclamp = shifted;
    end
  end

  // Inner error and its first and second differences.
  always_comb begin
    ei_nxt = EW'(cmd_r) - EW'(in_r.measured);
    dp_nxt = DW'(ei_nxt) - DW'(e1_r);
    dd_nxt = D2W'(ei_nxt) - (D2W'(e1_r) <<< 1) + D2W'(e2_r);
  end

  // Inner accumulator update and the drive value.
  always_comb begin
    asum   = (MW+1)'(iacc_r) + (MW+1)'(macc);
    alim_s = (MW+1)'(ACC_LIM);
    if (asum > alim_s) begin
      aclamp = alim_s;
    end else if (asum < -alim_s) begin
      aclamp = -alim_s;
    end else begin
      aclamp = asum;
    end
    iacc_nxt   = ACC_W'(aclamp);
    drive_full = iacc_nxt >>> GAIN_FRAC_BITS;
  end

  // Sequencer and shared unit operand selection.
  always_comb begin
    state_nxt = state_r;
    mac_ctrl  = '0;
    mac_gain  = op_gain_r;
    mac_opnd  = OW'(e_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: state_nxt = S_OM0;
      S_OM0: begin
        mac_ctrl  = '{mul: 1'b1, clr: 1'b1, add: 1'b0};
        state_nxt = S_OM1;
      end
      S_OM1: begin
        mac_ctrl  = '{mul: 1'b1, clr: 1'b0, add: 1'b1};
        mac_gain  = oi_gain_r;
        mac_opnd  = OW'(integ_r);
        state_nxt = S_OM2;
      end
      S_OM2: begin
        mac_ctrl  = '{mul: 1'b1, clr: 1'b0, add: 1'b1};
        mac_gain  = od_gain_r;
        mac_opnd  = OW'(de_r);
        state_nxt = S_OADD;
      end
      S_OADD: begin
        mac_ctrl  = '{mul: 1'b0, clr: 1'b0, add: 1'b1};
        state_nxt = S_CMD;
      end
      S_CMD:  state_nxt = S_IERR;
      S_IERR: state_nxt = S_IM0;
      S_IM0: begin
        mac_ctrl  = '{mul: 1'b1, clr: 1'b1, add: 1'b0};
        mac_gain  = ip_gain_r;
        mac_opnd  = OW'(dp_r);
        state_nxt = S_IM1;
      end
      S_IM1: begin
        mac_ctrl  = '{mul: 1'b1, clr: 1'b0, add: 1'b1};
        mac_gain  = ii_gain_r;
        mac_opnd  = OW'(ei_r);
        state_nxt = S_IM2;
      end
      S_IM2: begin
        mac_ctrl  = '{mul: 1'b1, clr: 1'b0, add: 1'b1};
        mac_gain  = id_gain_r;
        mac_opnd  = OW'(dd_r);
        state_nxt = S_IADD;
      end
      S_IADD: begin
        mac_ctrl  = '{mul: 1'b0, clr: 1'b0, add: 1'b1};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_gain_r   <= '0;
      oi_gain_r   <= '0;
      od_gain_r   <= '0;
      ilim_r      <= '0;
      olim_r      <= '0;
      ip_gain_r   <= '0;
      ii_gain_r   <= '0;
      id_gain_r   <= '0;
      outer_err_r <= '0;
      integ_r     <= '0;
      e1_r        <= '0;
      e2_r        <= '0;
      iacc_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          cpspid_pkg::REG_OUTER_P: op_gain_r <= cfg_data[GW-1:0];
          cpspid_pkg::REG_OUTER_I: oi_gain_r <= cfg_data[GW-1:0];
          cpspid_pkg::REG_OUTER_D: od_gain_r <= cfg_data[GW-1:0];
          cpspid_pkg::REG_INT_LIM: ilim_r    <= cfg_data[cpspid_pkg::ILIM_W-1:0];
          cpspid_pkg::REG_OUT_LIM: olim_r    <= cfg_data[cpspid_pkg::OLIM_W-1:0];
          cpspid_pkg::REG_INNER_P: ip_gain_r <= cfg_data[GW-1:0];
          cpspid_pkg::REG_INNER_I: ii_gain_r <= cfg_data[GW-1:0];
          cpspid_pkg::REG_INNER_D: id_gain_r <= cfg_data[GW-1:0];
          default: ;
        endcase
      end

      if (state_r == S_PREP) begin
        outer_err_r <= e_nxt;
        integ_r     <= IW'(iclamp);
      end

      if (state_r == S_FIN && out_free) begin
        e2_r        <= e1_r;
        e1_r        <= ei_r;
        iacc_r      <= iacc_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath words; these need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (state_r == S_PREP) begin
      e_r  <= e_nxt;
      de_r <= de_nxt;
    end
    if (state_r == S_CMD) begin
      cmd_r <= 16'(cclamp);
    end
    if (state_r == S_IERR) begin
      ei_r <= ei_nxt;
      dp_r <= dp_nxt;
      dd_r <= dd_nxt;
    end
    if (state_r == S_FIN && out_free) begin
      out_r.drive         <= 10'(drive_full);
      out_r.outer_command <= cmd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_PREP)
    else $error("accepted word did not start the outer loop");

  a_result_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result appeared outside the final step");

  a_acc_bound : assert property (@(posedge clk) disable iff (!rst_n)
    iacc_r <= ACC_LIM && iacc_r >= -ACC_LIM)
    else $error("inner accumulator outside its clamp");

  a_cmd_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.outer_command != 16'sh8000)
    else $error("outer command outside the symmetric range");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Cascade PID controller testbench
// Drives setpoint/measured words into the cascade controller and checks
// every result word against a cycle-free model of both loops. The test
// programs several gain and limit sets: reset values, full scale, zero
// limits, moderate and random. Random bursts of output stalls are applied
// throughout, and of input gaps in the random phases, except in the final phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int LATENCY        = 13;
  localparam int CYCLE_LIMIT    = 400000;

  localparam int CFG_IDX_W  = cpspid_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = cpspid_pkg::CFG_DATA_W;
  localparam int GAIN_W     = cpspid_pkg::GAIN_W;
  localparam int ILIM_W     = cpspid_pkg::ILIM_W;
  localparam int OLIM_W     = cpspid_pkg::OLIM_W;

  typedef enum {SET_TYPICAL, SET_WILD, SET_ZERO_LIMITS, SET_MAX, SET_ALL_ZERO} gain_set_t;

  localparam gain_set_t PHASE_SET[10] = '{SET_TYPICAL, SET_WILD, SET_ZERO_LIMITS, SET_TYPICAL,
                                          SET_MAX, SET_ALL_ZERO, SET_TYPICAL, SET_WILD,
                                          SET_TYPICAL, SET_TYPICAL};
  localparam int PHASE_ITEMS[10] = '{220, 180, 120, 220, 120, 40, 240, 160, 240, 310};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  cpspid_pkg::in_word_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  cpspid_pkg::out_word_t out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int stall_pct = 0;
  int cycle_count;

  // Model of both loops plus the queue of words the block still owes.
  class pid_scoreboard;
    bit [GAIN_W-1:0]       outer_kp, outer_ki, outer_kd;
    bit [GAIN_W-1:0]       inner_kp, inner_ki, inner_kd;
    bit [ILIM_W-1:0]       sum_limit;
    bit [OLIM_W-1:0]       cmd_limit;
    longint                outer_prev_err, outer_sum;
    longint                inner_e1, inner_e2, inner_acc;
    cpspid_pkg::out_word_t owed_q[$];
    int                    errors;

    function longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        cpspid_pkg::REG_OUTER_P: outer_kp  = data[GAIN_W-1:0];
        cpspid_pkg::REG_OUTER_I: outer_ki  = data[GAIN_W-1:0];
        cpspid_pkg::REG_OUTER_D: outer_kd  = data[GAIN_W-1:0];
        cpspid_pkg::REG_INT_LIM: sum_limit = data[ILIM_W-1:0];
        cpspid_pkg::REG_OUT_LIM: cmd_limit = data[OLIM_W-1:0];
        cpspid_pkg::REG_INNER_P: inner_kp  = data[GAIN_W-1:0];
        cpspid_pkg::REG_INNER_I: inner_ki  = data[GAIN_W-1:0];
        cpspid_pkg::REG_INNER_D: inner_kd  = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(cpspid_pkg::in_word_t w);
      longint                sp, meas, err, prev, total, cmd, ei, inc;
      cpspid_pkg::out_word_t want;
      sp   = w.setpoint;
      meas = w.measured;

      err            = sp - meas;
      prev           = outer_prev_err;
      outer_prev_err = err;
      outer_sum      = clamp_sym(outer_sum + err, longint'(sum_limit));
      total = longint'(outer_kp) * err + longint'(outer_ki) * outer_sum
            + longint'(outer_kd) * (err - prev);
      cmd = clamp_sym(total >>> GAIN_FRAC_BITS, longint'(cmd_limit));

      // The inner loop chases the clamped outer command.
      ei  = cmd - meas;
      inc = longint'(inner_kp) * (ei - inner_e1) + longint'(inner_ki) * ei
          + longint'(inner_kd) * (ei - 2 * inner_e1 + inner_e2);
      inner_e2  = inner_e1;
      inner_e1  = ei;
      inner_acc = clamp_sym(inner_acc + inc, longint'(500) <<< GAIN_FRAC_BITS);

      want.drive         = 10'(inner_acc >>> GAIN_FRAC_BITS);
      want.outer_command = 16'(cmd);
      owed_q.push_back(want);
    endfunction

    function void check_result(cpspid_pkg::out_word_t got);
      cpspid_pkg::out_word_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: drive %0d, outer_command %0d",
                 $time, got.drive, got.outer_command);
        return;
      end
      want = owed_q.pop_front();
      if (got.drive !== want.drive) report("drive", want.drive, got.drive);
      if (got.outer_command !== want.outer_command) begin
        report("outer_command", want.outer_command, got.outer_command);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  pid_scoreboard sb = new;

  cascade_position_speed_pid #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Result side back-pressure in random bursts.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Fills the bits above the register width with junk the block must ignore.
  function automatic logic [CFG_DATA_W-1:0] pad_high(int unsigned v, int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    return (junk << w) | CFG_DATA_W'(v);
  endfunction

  function automatic int pct_choice();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 50;
    endcase
  endfunction

  task automatic send_word(cpspid_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] okp, logic [CFG_DATA_W-1:0] oki,
                              logic [CFG_DATA_W-1:0] okd, logic [CFG_DATA_W-1:0] ilim,
                              logic [CFG_DATA_W-1:0] olim, logic [CFG_DATA_W-1:0] ikp,
                              logic [CFG_DATA_W-1:0] iki, logic [CFG_DATA_W-1:0] ikd);
    write_cfg(cpspid_pkg::REG_OUTER_P, okp);
    write_cfg(cpspid_pkg::REG_OUTER_I, oki);
    write_cfg(cpspid_pkg::REG_OUTER_D, okd);
    write_cfg(cpspid_pkg::REG_INT_LIM, ilim);
    write_cfg(cpspid_pkg::REG_OUT_LIM, olim);
    write_cfg(cpspid_pkg::REG_INNER_P, ikp);
    write_cfg(cpspid_pkg::REG_INNER_I, iki);
    write_cfg(cpspid_pkg::REG_INNER_D, ikd);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_setting(gain_set_t kind);
    logic [CFG_DATA_W-1:0] ilim, olim;
    case ($urandom_range(0, 2))
      0: ilim = CFG_DATA_W'($urandom_range(0, 50));
      1: ilim = CFG_DATA_W'($urandom_range(0, 5000));
      default: ilim = CFG_DATA_W'($urandom_range(0, 8388607));
    endcase
    case ($urandom_range(0, 2))
      0: olim = pad_high($urandom_range(0, 100), OLIM_W);
      1: olim = pad_high($urandom_range(0, 32767), OLIM_W);
      default: olim = pad_high(32767, OLIM_W);
    endcase
    case (kind)
      SET_MAX:      program_regs('1, '1, '1, '1, '1, '1, '1, '1);
      SET_ALL_ZERO: program_regs('0, '0, '0, '0, '0, '0, '0, '0);
      SET_ZERO_LIMITS: begin
        program_regs(pad_high($urandom_range(0, 1024), GAIN_W),
                     pad_high($urandom_range(0, 1024), GAIN_W),
                     pad_high($urandom_range(0, 1024), GAIN_W), '0, pad_high(0, OLIM_W),
                     pad_high($urandom_range(0, 256), GAIN_W),
                     pad_high($urandom_range(0, 256), GAIN_W),
                     pad_high($urandom_range(0, 256), GAIN_W));
      end
      SET_WILD: begin
        program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      end
      default: begin
        program_regs(pad_high($urandom_range(0, 768), GAIN_W),
                     pad_high($urandom_range(0, 768), GAIN_W),
                     pad_high($urandom_range(0, 768), GAIN_W), ilim, olim,
                     pad_high($urandom_range(0, 256), GAIN_W),
                     pad_high($urandom_range(0, 256), GAIN_W),
                     pad_high($urandom_range(0, 256), GAIN_W));
      end
    endcase
  endtask

  // Stops sending and waits until every owed result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly a plausible closed loop: a held setpoint with a measurement that
  // settles toward it plus noise. One word in ten is fully random.
  task automatic run_phase(int n_items, int gap_pct);
    int                   target, speed, hold, noise, span;
    cpspid_pkg::in_word_t w;
    target = 0;
    speed  = 0;
    hold   = 0;
    noise  = 0;
    repeat (n_items) begin
      if (hold == 0) begin
        case ($urandom_range(0, 2))
          0: span = 200;
          1: span = 3000;
          default: span = 32767;
        endcase
        target = pick_signed(span);
        case ($urandom_range(0, 3))
          0: noise = 0;
          1: noise = 3;
          2: noise = 50;
          default: noise = 500;
        endcase
        hold = $urandom_range(8, 40);
      end
      hold--;
      if ($urandom_range(0, 9) == 0) begin
        w = cpspid_pkg::in_word_t'($urandom);
      end else begin
        speed      = speed + (target - speed) / 8 + pick_signed(noise);
        w.setpoint = sat16(target);
        w.measured = sat16(speed);
      end
      send_word(w);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  endtask

  initial begin
    int gap;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With reset values every gain and limit is zero, so both outputs stay at zero.
    stall_pct = 20;
    send_word(cpspid_pkg::in_word_t'{16'sh7fff, 16'sh8000});
    send_word(cpspid_pkg::in_word_t'{16'sh8000, 16'sh7fff});
    wait_drained();

    program_setting(SET_MAX);
    send_word(cpspid_pkg::in_word_t'{16'sh7fff, 16'sh8000});
    send_word(cpspid_pkg::in_word_t'{16'sh8000, 16'sh7fff});
    send_word(cpspid_pkg::in_word_t'{16'sh0000, 16'sh0000});
    send_word(cpspid_pkg::in_word_t'{16'shffff, 16'shffff});
    send_word(cpspid_pkg::in_word_t'{16'sh7fff, 16'sh7fff});
    send_word(cpspid_pkg::in_word_t'{16'sh8000, 16'sh8000});
    wait_drained();

    // Moderate gains: the error sum runs into both sides of its bound.
    program_regs(CFG_DATA_W'(256), CFG_DATA_W'(64), CFG_DATA_W'(128), CFG_DATA_W'(100),
                 CFG_DATA_W'(1000), CFG_DATA_W'(64), CFG_DATA_W'(32), CFG_DATA_W'(16));
    repeat (3) send_word(cpspid_pkg::in_word_t'{16'sd50, 16'sd0});
    repeat (4) send_word(cpspid_pkg::in_word_t'{-16'sd60, 16'sd0});
    send_word(cpspid_pkg::in_word_t'{16'sd1000, -16'sd1000});
    send_word(cpspid_pkg::in_word_t'{16'sd0, 16'sd30000});
    send_word(cpspid_pkg::in_word_t'{16'sd0, -16'sd30000});
    send_word(cpspid_pkg::in_word_t'{16'sh8000, 16'sh7fff});
    send_word(cpspid_pkg::in_word_t'{16'sh7fff, 16'sh8000});
    wait_drained();

    program_setting(SET_ZERO_LIMITS);
    send_word(cpspid_pkg::in_word_t'{16'sd1234, -16'sd567});
    send_word(cpspid_pkg::in_word_t'{16'sh8000, 16'sh7fff});
    send_word(cpspid_pkg::in_word_t'{-16'sd300, 16'sd300});

    for (int p = 0; p < 10; p++) begin
      wait_drained();
      program_setting(PHASE_SET[p]);
      if (p == 9) begin
        stall_pct = 0;
        gap       = 0;
      end else begin
        stall_pct = pct_choice();
        gap       = pct_choice();
      end
      run_phase(PHASE_ITEMS[p], gap);
    end

    wait_drained();
    repeat (3 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
